@@ rtl/vna_pkg.sv @@
// Shared types and constants for the vertex normal accumulator.
// Used by every module of the block; depends on nothing.
package vna_pkg;

    localparam int COORD_W = 24;
    localparam int IDX_W   = 10;
    localparam int UNIT_W  = 16;
    localparam int STAT_W  = 2;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int MAG_W   = 31;
    localparam int QUO_W   = 17;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FACE   = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO      = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          a;
        logic [IDX_W-1:0]          b;
        logic [IDX_W-1:0]          c;
    } item_t;

endpackage

@@ rtl/vna_front.sv @@
// Input side: accepts words, decodes the request type and holds them in a two-entry queue.
// Depends on vna_pkg.
module vna_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic signed [vna_pkg::COORD_W-1:0] coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] coord_z,
    input  logic [vna_pkg::IDX_W-1:0]          corner_a,
    input  logic [vna_pkg::IDX_W-1:0]          corner_b,
    input  logic [vna_pkg::IDX_W-1:0]          corner_c,
    output logic                               q_valid,
    output vna_pkg::item_t                     q_item,
    input  logic                               q_pop
);
    import vna_pkg::*;

    item_t      slot_reg [2];
    item_t      new_item;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (fill_reg != 2'd0);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.op = op_t'(req_type);
        new_item.x  = coord_x;
        new_item.y  = coord_y;
        new_item.z  = coord_z;
        new_item.a  = corner_a;
        new_item.b  = corner_b;
        new_item.c  = corner_c;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

@@ rtl/vna_isqrt.sv @@
// Bit-pair integer square root of a 64-bit value, one result bit per cycle.
// Depends on vna_pkg.
module vna_isqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [vna_pkg::SUM_W-1:0]         radicand,
    output logic                              done,
    output logic [vna_pkg::ROOT_W-1:0]        root
);
    import vna_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] res_reg;
    logic [SUM_W-1:0] bit_reg;
    logic [SUM_W-1:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[ROOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd31);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= SUM_W'(1) << 62;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

@@ rtl/vna_div.sv @@
// Restoring divider giving round(mag * 32768 / divisor), one quotient bit per cycle.
// Depends on vna_pkg.
module vna_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vna_pkg::MAG_W-1:0]   mag,
    input  logic [vna_pkg::ROOT_W-1:0]  divisor,
    output logic                        done,
    output logic [vna_pkg::QUO_W-1:0]   quo
);
    import vna_pkg::*;

    localparam int NUM_W = MAG_W + 16;

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] div_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W:0]   trial;
    logic              fits;

    assign num   = NUM_W'({mag, 15'd0}) + NUM_W'(divisor[ROOT_W-1:1]);
    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'(QUO_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= ROOT_W'(num[NUM_W-1:QUO_W]);
            low_reg <= num[QUO_W-1:0];
            div_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= ROOT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= trial[ROOT_W-1:0];
            end
            low_reg <= low_reg << 1;
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

endmodule

@@ rtl/vna_back.sv @@
// Execution side: position and accumulator memories, face cross products, query normalization
// and the output register. Depends on vna_pkg, vna_isqrt and vna_div.
module vna_back #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  vna_pkg::item_t                    q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [vna_pkg::UNIT_W-1:0] unit_x,
    output logic signed [vna_pkg::UNIT_W-1:0] unit_y,
    output logic signed [vna_pkg::UNIT_W-1:0] unit_z,
    output logic [vna_pkg::STAT_W-1:0]        status
);
    import vna_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int PW = 3 * COORD_W;
    localparam int SW = 3 * SUM_W;
    localparam int DW = COORD_W + 1;
    localparam int PRW = 2 * DW;
    localparam int NW = PRW + 1;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_FRD   = 16'h0002,
        S_FDIFF = 16'h0004,
        S_FMUL  = 16'h0008,
        S_FSUB  = 16'h0010,
        S_ARD   = 16'h0020,
        S_AWR   = 16'h0040,
        S_QRD   = 16'h0080,
        S_QMAG  = 16'h0100,
        S_QNORM = 16'h0200,
        S_QSQ   = 16'h0400,
        S_QSUM  = 16'h0800,
        S_QSQRT = 16'h1000,
        S_QDST  = 16'h2000,
        S_QDIV  = 16'h4000,
        S_OUT   = 16'h8000
    } state_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] i, input logic [CW-1:0] n);
        return (CW + IDX_W)'(i) < (CW + IDX_W)'(n);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                  input logic signed [NW-1:0] inc);
        logic [SUM_W:0] s;
        s = {acc[SUM_W-1], acc} + (SUM_W + 1)'(inc);
        if (s[SUM_W] != s[SUM_W-1])
        begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic [UNIT_W-1:0] to_unit(input logic [QUO_W-1:0] q, input logic neg);
        logic [QUO_W-1:0] t;
        if (neg)
        begin
            t = (q > QUO_W'(32768)) ? QUO_W'(32768) : q;
            return UNIT_W'(QUO_W'(0) - t);
        end
        return (q > QUO_W'(32767)) ? UNIT_W'(32767) : q[UNIT_W-1:0];
    endfunction

    state_t                 state_reg;
    state_t                 state_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [1:0]             step_reg;
    logic [1:0]             step_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    item_t                  cur_reg;
    logic [IDX_W-1:0]       corner_sel;

    logic [PW-1:0]          pos_mem [MAX_VERTICES];
    logic [PW-1:0]          pos_rdata_reg;
    logic                   pos_we;
    logic [AW-1:0]          pos_raddr;
    logic [AW-1:0]          pos_waddr;
    logic [SW-1:0]          sum_mem [MAX_VERTICES];
    logic [SW-1:0]          sum_rdata_reg;
    logic                   sum_we;
    logic [AW-1:0]          sum_raddr;
    logic [AW-1:0]          sum_waddr;
    logic [SW-1:0]          sum_wdata;

    logic [PW-1:0]          pa_reg;
    logic [PW-1:0]          pb_reg;
    logic [PW-1:0]          pc_reg;
    logic signed [DW-1:0]   ux_reg;
    logic signed [DW-1:0]   uy_reg;
    logic signed [DW-1:0]   uz_reg;
    logic signed [DW-1:0]   wx_reg;
    logic signed [DW-1:0]   wy_reg;
    logic signed [DW-1:0]   wz_reg;
    logic signed [PRW-1:0]  pr_reg [6];
    logic signed [NW-1:0]   nx_reg;
    logic signed [NW-1:0]   ny_reg;
    logic signed [NW-1:0]   nz_reg;
    logic [SUM_W-1:0]       m_reg [3];
    logic                   neg_reg [3];
    logic [2*MAG_W-1:0]     sq_reg [3];
    logic [UNIT_W-1:0]      res_reg [3];
    logic [STAT_W-1:0]      stat_reg;
    logic [SUM_W-1:0]       orv;
    logic                   load_out;

    logic                   sqrt_start;
    logic                   sqrt_done;
    logic [SUM_W-1:0]       sqrt_in;
    logic [ROOT_W-1:0]      root;
    logic                   div_start;
    logic                   div_done;
    logic [QUO_W-1:0]       quo;

    logic [UNIT_W-1:0]      unit_x_reg;
    logic [UNIT_W-1:0]      unit_y_reg;
    logic [UNIT_W-1:0]      unit_z_reg;
    logic [STAT_W-1:0]      status_reg;

    assign corner_sel = (step_reg == 2'd0) ? cur_reg.a :
                        (step_reg == 2'd1) ? cur_reg.b : cur_reg.c;
    assign orv        = m_reg[0] | m_reg[1] | m_reg[2];
    assign sqrt_in    = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);

    assign out_valid = out_valid_reg;
    assign unit_x    = unit_x_reg;
    assign unit_y    = unit_y_reg;
    assign unit_z    = unit_z_reg;
    assign status    = status_reg;

    vna_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (root)
    );

    vna_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (m_reg[step_reg][MAG_W-1:0]),
        .divisor (root),
        .done    (div_done),
        .quo     (quo)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        pos_we     = 1'b0;
        sum_we     = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        pos_raddr  = AW'(corner_sel);
        sum_raddr  = AW'(corner_sel);
        pos_waddr  = AW'(count_reg);
        sum_waddr  = AW'(count_reg);
        sum_wdata  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    step_next = 2'd0;
                    case (q_item.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < CW'(MAX_VERTICES))
                            begin
                                pos_we     = 1'b1;
                                sum_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_FACE:
                        begin
                            if (idx_ok(q_item.a, count_reg) && idx_ok(q_item.b, count_reg)
                                && idx_ok(q_item.c, count_reg))
                            begin
                                state_next = S_FRD;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = idx_ok(q_item.a, count_reg) ? S_QRD : S_OUT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FRD:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = S_FDIFF;
                end
            end
            S_FDIFF: state_next = S_FMUL;
            S_FMUL:  state_next = S_FSUB;
            S_FSUB:
            begin
                step_next  = 2'd0;
                state_next = S_ARD;
            end
            S_ARD:   state_next = S_AWR;
            S_AWR:
            begin
                sum_we    = 1'b1;
                sum_waddr = AW'(corner_sel);
                sum_wdata = {sat_add(sum_rdata_reg[SW-1:2*SUM_W], nx_reg),
                             sat_add(sum_rdata_reg[2*SUM_W-1:SUM_W], ny_reg),
                             sat_add(sum_rdata_reg[SUM_W-1:0], nz_reg)};
                step_next  = step_reg + 2'd1;
                state_next = (step_reg == 2'd2) ? S_IDLE : S_ARD;
            end
            S_QRD:   state_next = S_QMAG;
            S_QMAG:  state_next = S_QNORM;
            S_QNORM:
            begin
                if (orv == '0)
                begin
                    state_next = S_OUT;
                end
                else if (orv[SUM_W-1:MAG_W] == '0 && orv[MAG_W-1])
                begin
                    state_next = S_QSQ;
                end
            end
            S_QSQ:   state_next = S_QSUM;
            S_QSUM:
            begin
                sqrt_start = 1'b1;
                state_next = S_QSQRT;
            end
            S_QSQRT:
            begin
                if (sqrt_done)
                begin
                    step_next  = 2'd0;
                    state_next = S_QDST;
                end
            end
            S_QDST:
            begin
                div_start  = 1'b1;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                if (div_done)
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = (step_reg == 2'd2) ? S_OUT : S_QDST;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= {q_item.x, q_item.y, q_item.z};
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_rdata_reg <= sum_mem[sum_raddr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cur_reg    <= q_item;
                    stat_reg   <= ST_BAD_INDEX;
                    res_reg[0] <= '0;
                    res_reg[1] <= '0;
                    res_reg[2] <= '0;
                end
            end
            S_FRD:
            begin
                if (step_reg == 2'd1)
                begin
                    pa_reg <= pos_rdata_reg;
                end
                if (step_reg == 2'd2)
                begin
                    pb_reg <= pos_rdata_reg;
                end
                if (step_reg == 2'd3)
                begin
                    pc_reg <= pos_rdata_reg;
                end
            end
            S_FDIFF:
            begin
                ux_reg <= DW'(signed'(pb_reg[PW-1:2*COORD_W]))
                        - DW'(signed'(pa_reg[PW-1:2*COORD_W]));
                uy_reg <= DW'(signed'(pb_reg[2*COORD_W-1:COORD_W]))
                        - DW'(signed'(pa_reg[2*COORD_W-1:COORD_W]));
                uz_reg <= DW'(signed'(pb_reg[COORD_W-1:0]))
                        - DW'(signed'(pa_reg[COORD_W-1:0]));
                wx_reg <= DW'(signed'(pc_reg[PW-1:2*COORD_W]))
                        - DW'(signed'(pa_reg[PW-1:2*COORD_W]));
                wy_reg <= DW'(signed'(pc_reg[2*COORD_W-1:COORD_W]))
                        - DW'(signed'(pa_reg[2*COORD_W-1:COORD_W]));
                wz_reg <= DW'(signed'(pc_reg[COORD_W-1:0]))
                        - DW'(signed'(pa_reg[COORD_W-1:0]));
            end
            S_FMUL:
            begin
                pr_reg[0] <= uy_reg * wz_reg;
                pr_reg[1] <= uz_reg * wy_reg;
                pr_reg[2] <= uz_reg * wx_reg;
                pr_reg[3] <= ux_reg * wz_reg;
                pr_reg[4] <= ux_reg * wy_reg;
                pr_reg[5] <= uy_reg * wx_reg;
            end
            S_FSUB:
            begin
                nx_reg <= NW'(pr_reg[0]) - NW'(pr_reg[1]);
                ny_reg <= NW'(pr_reg[2]) - NW'(pr_reg[3]);
                nz_reg <= NW'(pr_reg[4]) - NW'(pr_reg[5]);
            end
            S_QMAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= sum_rdata_reg[(3-i)*SUM_W-1];
                    m_reg[i]   <= sum_rdata_reg[(3-i)*SUM_W-1]
                                ? (~sum_rdata_reg[(2-i)*SUM_W +: SUM_W] + SUM_W'(1))
                                : sum_rdata_reg[(2-i)*SUM_W +: SUM_W];
                end
            end
            S_QNORM:
            begin
                if (orv == '0)
                begin
                    stat_reg <= ST_ZERO;
                end
                else if (orv[SUM_W-1:MAG_W] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
                else if (!orv[MAG_W-1])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            S_QSQ:
            begin
                stat_reg <= ST_OK;
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= m_reg[i][MAG_W-1:0] * m_reg[i][MAG_W-1:0];
                end
            end
            S_QDIV:
            begin
                if (div_done)
                begin
                    res_reg[step_reg] <= to_unit(quo, neg_reg[step_reg]);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            unit_x_reg <= res_reg[0];
            unit_y_reg <= res_reg[1];
            unit_z_reg <= res_reg[2];
            status_reg <= stat_reg;
        end
    end

endmodule

@@ rtl/vertex_normal_accumulator.sv @@
// Area-weighted vertex normal accumulator: clear, append, face and query words.
// Clear and append complete in the idle state; a face takes three position reads, the cross product
// and three accumulator read-modify-writes; a query takes the one-bit normalizing shifts,
// the 32-step square root and three 17-step divisions.
// A two-word input queue and an output register decouple both sides; reset clears control
// only, and an accumulator entry is zeroed when its vertex is appended, so no clearing pass.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         req_type,
    input  logic signed [vna_pkg::COORD_W-1:0] coord_x,
    input  logic signed [vna_pkg::COORD_W-1:0] coord_y,
    input  logic signed [vna_pkg::COORD_W-1:0] coord_z,
    input  logic [vna_pkg::IDX_W-1:0]          corner_a,
    input  logic [vna_pkg::IDX_W-1:0]          corner_b,
    input  logic [vna_pkg::IDX_W-1:0]          corner_c,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [vna_pkg::UNIT_W-1:0]  unit_x,
    output logic signed [vna_pkg::UNIT_W-1:0]  unit_y,
    output logic signed [vna_pkg::UNIT_W-1:0]  unit_z,
    output logic [vna_pkg::STAT_W-1:0]         status
);
    import vna_pkg::*;

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    vna_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .coord_z  (coord_z),
        .corner_a (corner_a),
        .corner_b (corner_b),
        .corner_c (corner_c),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    vna_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .status    (status)
    );

endmodule

@@ bench/tb_vertex_normal_accumulator.sv @@
// Self-checking testbench for vertex_normal_accumulator: directed table, full list, random.
// Depends on rtl/vna_pkg.sv and rtl/vertex_normal_accumulator.sv; expected normals come from an
// in-bench mesh model, or from the table itself for rows marked typed.
module tb_vertex_normal_accumulator;
    import vna_pkg::*;

    localparam int NVERT = 1024;

    typedef struct {
        op_t op;
        int  x, y, z, a, b, c;
    } word_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] ux, uy, uz;
        logic [STAT_W-1:0]        st;
    } normal_t;

    typedef struct {
        word_t   w;
        bit      typed;
        normal_t n;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic out_stall = 0;
    logic [1:0] req_type = 0;
    logic signed [COORD_W-1:0] coord_x = 0, coord_y = 0, coord_z = 0;
    logic [IDX_W-1:0] corner_a = 0, corner_b = 0, corner_c = 0;
    logic in_stall, out_valid;
    logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
    logic [STAT_W-1:0] status;

    longint pos_x [NVERT], pos_y [NVERT], pos_z [NVERT];
    longint sum_x [NVERT], sum_y [NVERT], sum_z [NVERT];
    int vert_count = 0;
    normal_t pending_normals [$];
    int mismatches = 0;
    longint cycles = 0;
    bit idle_on = 1;
    int hold_request = 0;
    bit take;
    normal_t seen;

    vertex_normal_accumulator DUT (.*);

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 8_000_000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return s[63:0];
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned bt = 64'h4000000000000000;
        while (bt > n)
            bt >>= 2;
        while (bt != 0)
        begin
            if (n >= r + bt)
            begin
                n -= r + bt;
                r = (r >> 1) + bt;
            end
            else
                r >>= 1;
            bt >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [UNIT_W-1:0] to_unit(longint s, longint unsigned m,
                                                         longint unsigned len);
        longint unsigned q;
        q = (m * 32768 + len / 2) / len;
        if (s < 0)
        begin
            if (q > 32768)
                q = 32768;
            return -q[UNIT_W-1:0];
        end
        if (q > 32767)
            q = 32767;
        return q[UNIT_W-1:0];
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? 64'd0 - longint'(v) : v;
    endfunction

    // Applies one word to the mesh model; returns 1 when it yields a normal.
    function automatic bit apply_word(word_t w, output normal_t n);
        longint ux, uy, uz, wx, wy, wz, nx, ny, nz;
        longint unsigned mx, my, mz, top, len;
        int idx [3];
        n = '{0, 0, 0, ST_OK};
        case (w.op)
            OP_CLEAR:
            begin
                vert_count = 0;
                for (int i = 0; i < NVERT; i++)
                begin
                    sum_x[i] = 0;
                    sum_y[i] = 0;
                    sum_z[i] = 0;
                end
                return 0;
            end
            OP_APPEND:
            begin
                if (vert_count < NVERT)
                begin
                    pos_x[vert_count] = w.x;
                    pos_y[vert_count] = w.y;
                    pos_z[vert_count] = w.z;
                    sum_x[vert_count] = 0;
                    sum_y[vert_count] = 0;
                    sum_z[vert_count] = 0;
                    vert_count++;
                end
                return 0;
            end
            OP_FACE:
            begin
                if (w.a >= vert_count || w.b >= vert_count || w.c >= vert_count)
                    return 0;
                ux = pos_x[w.b] - pos_x[w.a];
                uy = pos_y[w.b] - pos_y[w.a];
                uz = pos_z[w.b] - pos_z[w.a];
                wx = pos_x[w.c] - pos_x[w.a];
                wy = pos_y[w.c] - pos_y[w.a];
                wz = pos_z[w.c] - pos_z[w.a];
                nx = uy * wz - uz * wy;
                ny = uz * wx - ux * wz;
                nz = ux * wy - uy * wx;
                idx = '{w.a, w.b, w.c};
                foreach (idx[k])
                begin
                    sum_x[idx[k]] = sat_add(sum_x[idx[k]], nx);
                    sum_y[idx[k]] = sat_add(sum_y[idx[k]], ny);
                    sum_z[idx[k]] = sat_add(sum_z[idx[k]], nz);
                end
                return 0;
            end
            default:
            begin
                if (w.a >= vert_count)
                begin
                    n.st = ST_BAD_INDEX;
                    return 1;
                end
                mx = magnitude(sum_x[w.a]);
                my = magnitude(sum_y[w.a]);
                mz = magnitude(sum_z[w.a]);
                top = mx;
                if (my > top)
                    top = my;
                if (mz > top)
                    top = mz;
                if (top == 0)
                begin
                    n.st = ST_ZERO;
                    return 1;
                end
                while (top >= 64'd1 << 31)
                begin
                    top >>= 1;
                    mx >>= 1;
                    my >>= 1;
                    mz >>= 1;
                end
                while (top < 64'd1 << 30)
                begin
                    top <<= 1;
                    mx <<= 1;
                    my <<= 1;
                    mz <<= 1;
                end
                len = root64(mx * mx + my * my + mz * mz);
                n.ux = to_unit(sum_x[w.a], mx, len);
                n.uy = to_unit(sum_y[w.a], my, len);
                n.uz = to_unit(sum_z[w.a], mz, len);
                return 1;
            end
        endcase
    endfunction

    task automatic send_word(word_t w, bit typed = 0, normal_t tn = '{0, 0, 0, ST_OK});
        normal_t n;
        bit accepted;
        while (idle_on && $urandom_range(99) < 27)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        req_type <= w.op;
        coord_x <= COORD_W'(w.x);
        coord_y <= COORD_W'(w.y);
        coord_z <= COORD_W'(w.z);
        corner_a <= IDX_W'(w.a);
        corner_b <= IDX_W'(w.b);
        corner_c <= IDX_W'(w.c);
        do
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        while (!accepted);
        if (apply_word(w, n))
            pending_normals = {pending_normals, typed ? tn : n};
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_normals.size() != 0)
            @(posedge clk);
    endtask

    function automatic int rand_coord();
        if ($urandom_range(1))
            return $signed($urandom_range(24'hffffff) << 8) >>> 8;
        return $signed($urandom_range(8191)) - 4096;
    endfunction

    function automatic int rand_index();
        if (vert_count > 0 && $urandom_range(99) < 90)
            return $urandom_range(vert_count - 1);
        return $urandom_range(NVERT - 1);
    endfunction

    function automatic word_t rand_word();
        word_t w;
        int r;
        r = $urandom_range(99);
        w.op = r < 1 ? OP_CLEAR : r < 30 ? OP_APPEND : r < 70 ? OP_FACE : OP_QUERY;
        w.x = rand_coord();
        w.y = rand_coord();
        w.z = rand_coord();
        w.a = rand_index();
        w.b = rand_index();
        w.c = rand_index();
        return w;
    endfunction

    always @(negedge clk)
    begin
        take = out_valid && !out_stall;
        seen = '{unit_x, unit_y, unit_z, status};
    end

    always @(posedge clk)
    begin
        if (rst_n && take)
        begin
            if (pending_normals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected normal %0d %0d %0d status %0d",
                             seen.ux, seen.uy, seen.uz, seen.st);
            end
            else if (pending_normals[0] !== seen)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("normal expected %0d %0d %0d/%0d, got %0d %0d %0d/%0d",
                             pending_normals[0].ux, pending_normals[0].uy,
                             pending_normals[0].uz, pending_normals[0].st,
                             seen.ux, seen.uy, seen.uz, seen.st);
                void'(pending_normals.pop_front());
            end
            else
                void'(pending_normals.pop_front());
        end
    end

    initial
    begin
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
                out_stall <= 1;
                repeat (held)
                    @(posedge clk);
            end
            out_stall <= idle_on && $urandom_range(99) < 27;
        end
    end

    initial
    begin
        row_t table_rows [];
        word_t w;
        table_rows = '{
            '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, ST_BAD_INDEX}},
            '{'{OP_APPEND, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_APPEND, 256, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_APPEND, 0, 256, 0, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, ST_ZERO}},
            '{'{OP_FACE, 0, 0, 0, 0, 1, 2}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 1, 0, 0}, 1, '{0, 0, 32767, ST_OK}},
            '{'{OP_FACE, 0, 0, 0, 0, 1, 3}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_FACE, 0, 0, 0, 0, 0, 1}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_FACE, 0, 0, 0, 0, 2, 1}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 2, 0, 0}, 1, '{0, 0, 0, ST_ZERO}},
            '{'{OP_APPEND, 8388607, 8388607, 8388607, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_APPEND, -8388608, -8388608, -8388608, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_APPEND, 8388607, -8388608, 0, 0, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_FACE, 0, 0, 0, 3, 4, 5}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_FACE, 0, 0, 0, 5, 1, 3}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 3, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 4, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 5, 0, 0}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 1023, 0, 0}, 1, '{0, 0, 0, ST_BAD_INDEX}},
            '{'{OP_FACE, 0, 0, 0, 1023, 1023, 1023}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 6, 0, 0}, 1, '{0, 0, 0, ST_BAD_INDEX}},
            '{'{OP_FACE, 0, 0, 0, 0, 2, 1}, 0, '{0, 0, 0, ST_OK}},
            '{'{OP_QUERY, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, -32768, ST_OK}}
        };
        repeat (6)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (table_rows[i])
            send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].n);

        // Fill the vertex list past its capacity.
        drain();
        send_word('{OP_CLEAR, 0, 0, 0, 0, 0, 0});
        repeat (NVERT + 6)
        begin
            w = rand_word();
            w.op = OP_APPEND;
            send_word(w);
        end
        send_word('{OP_FACE, 0, 0, 0, 1021, 1022, 1023});
        send_word('{OP_FACE, 0, 0, 0, 1023, 0, 511});
        send_word('{OP_QUERY, 0, 0, 0, 1023, 0, 0});
        send_word('{OP_QUERY, 0, 0, 0, 512, 0, 0});
        drain();

        for (int i = 0; i < 190; i++)
        begin
            if (i == 40)
                hold_request = 500;
            if (i == 100)
                drain();
            idle_on = !(i >= 120 && i < 170);
            send_word(rand_word());
        end
        drain();
        repeat (300)
            @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/vna_pkg.sv
rtl/vna_front.sv
rtl/vna_isqrt.sv
rtl/vna_div.sv
rtl/vna_back.sv
rtl/vertex_normal_accumulator.sv
bench/tb_vertex_normal_accumulator.sv
